// ===== rtl/hmps_pkg.sv =====
// shared types and constants of the hashed material pixel shader
package hmps_pkg;

  // field widths
  localparam int unsigned CoordW    = 16;
  localparam int unsigned CodeInW   = 3;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned RgbW      = 3 * ChanW;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = RgbW;

  // register map
  localparam logic [CfgIndexW-1:0] CfgIdxSolidMask  = 3'd0;
  localparam logic [CfgIndexW-1:0] CfgIdxColourBase = 3'd1;

  // register file sizes and reset values
  localparam int unsigned ColourRegs     = 6;
  localparam logic [5:0]  SolidMaskReset = 6'd30;

  // hash mixing constants
  localparam logic [31:0] HashMulX   = 32'd374761393;
  localparam logic [31:0] HashMulY   = 32'd668265263;
  localparam logic [31:0] HashMulMix = 32'd1274126177;

  // hash mod 1000 through reciprocal multiply: q = (h * recip) >> 38
  localparam logic [31:0] Div1000Recip = 32'h10624DD3;
  localparam logic [9:0]  Modulus      = 10'd1000;

  // brightness scale 8500 + 3k, then divide by 10000 via reciprocal (>> 36)
  localparam int unsigned ScaleW       = 14;
  localparam logic [ScaleW-1:0] ScaleBase = 14'd8500;
  localparam int unsigned ProdW        = ChanW + ScaleW;
  localparam int unsigned RecipW       = 23;
  localparam logic [RecipW-1:0] Div10kRecip = 23'd6871948;
  localparam int unsigned Div10kShift  = 36;
  localparam int unsigned QuotW        = 9;

  localparam logic [ChanW-1:0] ChanMax = 8'hFF;

  // register stages from accept to result
  localparam int unsigned PipeDepth = 9;

  typedef struct packed {
    logic [CoordW-1:0]  pixel_x;
    logic [CoordW-1:0]  pixel_y;
    logic [CodeInW-1:0] material_code;
  } pixel_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic [ChanW-1:0] alpha_out;
  } pixel_out_t;

endpackage

// ===== rtl/hashed_material_pixel_shader_core.sv =====
// hashed material pixel shader: nine-stage pipeline from pixel item to rgba result
//
// Usage
//   Pixel items enter on pixel_i; an item is taken at a rising edge where start is
//   high and busy is low. busy is high only while reset is held and for the first
//   cycle after it; afterwards one item is taken in every cycle where start is high.
//   Each item gives one result on result_o, marked by result_valid_o for exactly
//   one cycle, once it has passed through the nine register stages. Results leave in order.
//   Throughput is one item per cycle once busy is low; the pipeline depth is set by the
//   dependent multiplies (coordinate products, hash mix, mod-1000 reciprocal, channel
//   scale, divide by 10000 reciprocal), each followed by a register stage.
//   The receiver cannot stall, so the pipeline never holds; valid bits move with
//   the data every cycle.
//   Configuration is written on the cfg channel (cfg_ready_o is always high):
//   index 0 is the solid mask, index 1 to 6 the colour of material 0 to 5.
//   Writes to other indexes are dropped. Write only while no item is in flight.
//   Reset clears the pipeline valid bits and loads the register reset values
//   (solid mask 30, colours zero).
module hashed_material_pixel_shader_core
  import hmps_pkg::*;
#(
  parameter int unsigned MATERIAL_COUNT = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  pixel_in_t            pixel_i,
  output logic                 result_valid_o,
  output pixel_out_t           result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned NumColours = (MATERIAL_COUNT < ColourRegs) ? MATERIAL_COUNT
                                                                     : ColourRegs;
  localparam int unsigned ColIdxW    = (NumColours > 1) ? $clog2(NumColours) : 1;

  // configuration registers
  logic [NumColours-1:0] mask_q;
  logic [RgbW-1:0]       colour_q [NumColours];
  logic [CfgIndexW-1:0]  cfg_col_idx;
  logic                  cfg_col_hit;

  assign cfg_ready_o = 1'b1;
  assign cfg_col_idx = cfg_index_i - CfgIdxColourBase;
  assign cfg_col_hit = (cfg_index_i != CfgIdxSolidMask) &&
                       (cfg_col_idx < CfgIndexW'(NumColours));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= SolidMaskReset[NumColours-1:0];
      for (int i = 0; i < NumColours; i++) begin
        colour_q[i] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgIdxSolidMask) begin
        mask_q <= cfg_data_i[NumColours-1:0];
      end else if (cfg_col_hit) begin
        colour_q[cfg_col_idx[ColIdxW-1:0]] <= cfg_data_i;
      end
    end
  end

  // control: busy during reset and in the cycle after it, valid bits down the pipe
  logic                 busy_q;
  logic [PipeDepth-1:0] vld_q;
  logic                 accept;

  assign busy   = busy_q;
  assign accept = start && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      vld_q  <= '0;
    end else begin
      busy_q <= 1'b0;
      vld_q  <= {vld_q[PipeDepth-2:0], accept};
    end
  end

  // material lookup at entry
  logic            in_solid;
  logic [RgbW-1:0] in_rgb;

  always_comb begin
    in_solid = 1'b0;
    in_rgb   = '0;
    if (pixel_i.material_code < CodeInW'(NumColours)) begin
      in_solid = mask_q[pixel_i.material_code[ColIdxW-1:0]];
      in_rgb   = colour_q[pixel_i.material_code[ColIdxW-1:0]];
    end
  end

  // sideband: solid flag and base colour travel with the item
  logic [PipeDepth-2:0] solid_q;
  logic [RgbW-1:0]      rgb_q [PipeDepth-3];

  // datapath stage registers
  logic [31:0]        mx_q, my_q;   // s1: coordinate products
  logic [31:0]        t_q;          // s2: sum with xor-shift
  logic [31:0]        m_q;          // s3: mix multiply
  logic [31:0]        h_q;          // s4: final hash
  logic [31:0]        h5_q;         // s5: hash kept for remainder
  logic [63:0]        p_q;          // s5: reciprocal product
  logic [9:0]         k_q;          // s6: hash mod 1000
  logic [ProdW-1:0]   prod_q [3];   // s7: channel times scale
  logic [ProdW+RecipW-1:0] rcp_q [3]; // s8: reciprocal products
  pixel_out_t         out_q;        // s9: result

  // combinational pieces between stages
  logic [31:0]        h1, m_sh, quot_x1000;
  logic [22:0]        quot;
  logic [ScaleW-1:0]  scale;
  logic [ChanW-1:0]   chan [3];
  logic [QuotW-1:0]   dq [3];
  logic [ChanW-1:0]   shaded [3];

  assign h1         = mx_q + my_q;
  assign m_sh       = m_q ^ (m_q >> 16);
  assign quot       = p_q[60:38];
  assign quot_x1000 = 32'(quot) * 32'(Modulus);
  assign scale      = ScaleBase + ScaleW'(k_q) + ScaleW'({k_q, 1'b0});
  assign chan[0]    = rgb_q[PipeDepth-4][23:16];
  assign chan[1]    = rgb_q[PipeDepth-4][15:8];
  assign chan[2]    = rgb_q[PipeDepth-4][7:0];

  // divide by 10000 and saturate
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dq[c]     = rcp_q[c][Div10kShift +: QuotW];
      shaded[c] = (dq[c] > QuotW'(ChanMax)) ? ChanMax : dq[c][ChanW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    // s1
    mx_q <= 32'(32'(pixel_i.pixel_x) * HashMulX);
    my_q <= 32'(32'(pixel_i.pixel_y) * HashMulY);
    // s2
    t_q  <= h1 ^ (h1 >> 13);
    // s3
    m_q  <= 32'(t_q * HashMulMix);
    // s4
    h_q  <= m_sh;
    // s5
    h5_q <= h_q;
    p_q  <= 64'(h_q) * 64'(Div1000Recip);
    // s6
    k_q  <= 10'(h5_q - quot_x1000);
    // s7, s8
    for (int c = 0; c < 3; c++) begin
      prod_q[c] <= ProdW'(chan[c]) * ProdW'(scale);
      rcp_q[c]  <= (ProdW + RecipW)'(prod_q[c]) * (ProdW + RecipW)'(Div10kRecip);
    end
    // s9
    if (solid_q[PipeDepth-2]) begin
      out_q <= '{red_out: shaded[0], green_out: shaded[1], blue_out: shaded[2],
                 alpha_out: ChanMax};
    end else begin
      out_q <= '0;
    end
    // sideband shift
    solid_q  <= {solid_q[PipeDepth-3:0], in_solid};
    rgb_q[0] <= in_rgb;
    for (int s = 1; s < PipeDepth - 3; s++) begin
      rgb_q[s] <= rgb_q[s-1];
    end
  end

  assign result_valid_o = vld_q[PipeDepth-1];
  assign result_o       = out_q;

endmodule

// ===== rtl/hmps_checker.sv =====
// port-level checker for the pixel shader core and its bind
module hmps_checker
  import hmps_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_i,
  input logic       result_valid_i,
  input pixel_out_t result_i
);

  // every result comes from an item taken a fixed latency earlier
  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i |-> $past(start_i && !busy_i, PipeDepth))
    else $error("result without an item taken at the pipeline latency");

  // every taken item gives a result after the fixed latency
  a_item_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i) |-> ##PipeDepth result_valid_i)
    else $error("item taken but no result at the pipeline latency");

  // alpha is either fully transparent or fully opaque
  a_alpha_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i |-> (result_i.alpha_out == 8'h00 || result_i.alpha_out == ChanMax))
    else $error("alpha neither zero nor full");

  // transparent result carries no colour
  a_clear_is_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_i && result_i.alpha_out == 8'h00) |->
      (result_i.red_out == 8'h00 && result_i.green_out == 8'h00 &&
       result_i.blue_out == 8'h00))
    else $error("non-solid result with colour");

endmodule

bind hashed_material_pixel_shader_core hmps_checker u_hmps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start),
  .busy_i         (busy),
  .result_valid_i (result_valid_o),
  .result_i       (result_o)
);
